// File: rtl/fst_pkg.sv
// Shared types and constants for the fader soft-takeover / button-toggle block.
// Holds the item, result, config, flag and state-update structs and the command codes.
// No dependencies.
package fst_pkg;

  // value format: unsigned fraction, all ones means 1.0
  localparam int VALUE_BITS  = 14;
  localparam int FADER_SCALE = ((1 << VALUE_BITS) - 1) / 127;

  typedef logic [VALUE_BITS-1:0] fst_val_t;

  localparam fst_val_t VAL_FULL = {VALUE_BITS{1'b1}};

  // input commands
  localparam logic [1:0] CMD_BUTTON   = 2'd0;
  localparam logic [1:0] CMD_FADER    = 2'd1;
  localparam logic [1:0] CMD_FEEDBACK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LED   = 2'd0;
  localparam logic [1:0] KIND_HOST  = 2'd1;
  localparam logic [1:0] KIND_CATCH = 2'd2;

  // configuration register map
  localparam int         CFG_ADDR_W     = 4;
  localparam logic [1:0] REG_BANK_LEFT  = 2'd0;
  localparam logic [1:0] REG_BANK_RIGHT = 2'd1;
  localparam logic [1:0] REG_CATCH_TOL  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] control_number;
    logic       is_fader;
    logic [6:0] raw_value;
    fst_val_t   feedback_value;
  } fst_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] target_number;
    logic       led_on;
    fst_val_t   host_value;
    logic       last_result;
  } fst_out_t;

  typedef struct packed {
    logic [6:0] bank_left_number;
    logic [6:0] bank_right_number;
    fst_val_t   catch_tolerance;
  } fst_cfg_t;

  // per-control flags kept in the flag RAM
  typedef struct packed {
    logic toggle;
    logic moved_valid;
    logic pending_valid;
  } fst_flags_t;

  // per-control state writes produced by one item
  typedef struct packed {
    logic     toggle_we;
    logic     toggle_val;
    logic     moved_we;
    fst_val_t moved_val;
    logic     pending_we;
    fst_val_t pending_val;
    logic     pending_valid_we;
    logic     pending_valid_val;
  } fst_upd_t;

endpackage

// File: rtl/fst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the per-control value and flag stores. No dependencies.
module fst_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fst_cfg.sv
// APB-style configuration registers: bank button numbers and catch tolerance.
// Depends on fst_pkg.
module fst_cfg
  import fst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output fst_cfg_t              cfg_o
);

  fst_cfg_t   cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // write registers on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bank_left_number  <= 7'd126;
      cfg_q.bank_right_number <= 7'd127;
      cfg_q.catch_tolerance   <= fst_val_t'(164);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BANK_LEFT:  cfg_q.bank_left_number  <= pwdata[6:0];
        REG_BANK_RIGHT: cfg_q.bank_right_number <= pwdata[6:0];
        REG_CATCH_TOL:  cfg_q.catch_tolerance   <= pwdata[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BANK_LEFT:  prdata = 32'(cfg_q.bank_left_number);
      REG_BANK_RIGHT: prdata = 32'(cfg_q.bank_right_number);
      REG_CATCH_TOL:  prdata = 32'(cfg_q.catch_tolerance);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/fst_eval.sv
// Per-item decision logic: button toggle, fader soft takeover, host feedback.
// Produces up to two results and the per-control state writes. Depends on fst_pkg.
module fst_eval
  import fst_pkg::*;
(
  input  fst_in_t    item_i,
  input  fst_cfg_t   cfg_i,
  input  logic       in_range_i,
  input  logic       toggle_i,
  input  logic       moved_valid_i,
  input  fst_val_t   moved_i,
  input  logic       pending_valid_i,
  input  fst_val_t   pending_i,
  output fst_out_t   res0_o,
  output fst_out_t   res1_o,
  output logic [1:0] nres_o,
  output fst_upd_t   upd_o
);

  fst_val_t fader_val;
  fst_val_t diff_vp;
  fst_val_t diff_fm;
  logic     pressed;
  logic     is_bank;
  logic     toggle_new;
  logic     crossed;
  logic     close_vp;
  logic     keep;
  logic     fb_near;

  // 7-bit position to full-scale value
  assign fader_val = fst_val_t'(item_i.raw_value * FADER_SCALE);
  assign pressed   = (item_i.raw_value != 7'd0);
  assign is_bank   = (item_i.control_number == cfg_i.bank_left_number) ||
                     (item_i.control_number == cfg_i.bank_right_number);
  assign toggle_new = toggle_i ^ pressed;

  // distances for the catch tests
  assign diff_vp = (fader_val >= pending_i) ? fader_val - pending_i : pending_i - fader_val;
  assign diff_fm = (item_i.feedback_value >= moved_i) ? item_i.feedback_value - moved_i
                                                      : moved_i - item_i.feedback_value;

  // pending value lies between the new and the last position
  assign crossed  = moved_valid_i &&
                    (((fader_val <= pending_i) && (pending_i <= moved_i)) ||
                     ((fader_val >= pending_i) && (pending_i >= moved_i)));
  assign close_vp = (diff_vp < cfg_i.catch_tolerance);
  assign keep     = pending_valid_i && !(crossed || close_vp);
  assign fb_near  = moved_valid_i && (diff_fm < cfg_i.catch_tolerance);

  always_comb begin
    res0_o = '0;
    res1_o = '0;
    res0_o.target_number = item_i.control_number;
    res1_o.target_number = item_i.control_number;
    nres_o = 2'd0;
    upd_o  = '0;
    upd_o.moved_val   = fader_val;
    upd_o.pending_val = item_i.feedback_value;
    upd_o.toggle_val  = toggle_new;

    if (in_range_i) begin
      unique case (item_i.command)
        CMD_BUTTON: begin
          if (is_bank) begin
            // momentary bank control: host value only
            res0_o.kind        = KIND_HOST;
            res0_o.host_value  = pressed ? VAL_FULL : '0;
            res0_o.last_result = 1'b1;
            nres_o             = 2'd1;
          end else begin
            // flip on press, then report LED and host value
            upd_o.toggle_we    = 1'b1;
            res0_o.kind        = KIND_LED;
            res0_o.led_on      = toggle_new;
            res1_o.kind        = KIND_HOST;
            res1_o.host_value  = toggle_new ? VAL_FULL : '0;
            res1_o.last_result = 1'b1;
            nres_o             = 2'd2;
          end
        end
        CMD_FADER: begin
          upd_o.moved_we          = 1'b1;
          upd_o.pending_valid_we  = 1'b1;
          upd_o.pending_valid_val = keep;
          res0_o.kind             = KIND_CATCH;
          if (keep) begin
            // not yet caught: status only
            res0_o.led_on      = 1'b1;
            res0_o.last_result = 1'b1;
            nres_o             = 2'd1;
          end else begin
            // caught: status, then forward the move
            res1_o.kind        = KIND_HOST;
            res1_o.host_value  = fader_val;
            res1_o.last_result = 1'b1;
            nres_o             = 2'd2;
          end
        end
        CMD_FEEDBACK: begin
          res0_o.last_result = 1'b1;
          nres_o             = 2'd1;
          if (!item_i.is_fader) begin
            res0_o.kind   = KIND_LED;
            res0_o.led_on = item_i.feedback_value[VALUE_BITS-1];
          end else begin
            // near the fader: caught at once, else hold as pending
            upd_o.pending_valid_we  = 1'b1;
            upd_o.pending_valid_val = !fb_near;
            upd_o.pending_we        = !fb_near;
            res0_o.kind             = KIND_CATCH;
            res0_o.led_on           = !fb_near;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/fst_outbuf.sv
// Two-slot result buffer: takes all results of one item at once, sends one beat
// a cycle while out_stall_i is low. Depends on fst_pkg.
module fst_outbuf
  import fst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  fst_out_t   res0_i,
  input  fst_out_t   res1_i,
  input  logic [1:0] nres_i,
  output logic       load_ok_o,
  output logic       out_valid_o,
  output fst_out_t   out_data_o,
  input  logic       out_stall_i
);

  fst_out_t   slot_q [2];
  logic [1:0] cnt_q;
  logic       head_q;
  logic       pop;
  logic [1:0] cnt_after;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[head_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign cnt_after   = cnt_q - {1'b0, pop};
  assign load_ok_o   = (cnt_after == 2'd0);

  // control: count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else if (load_i) begin
      cnt_q  <= nres_i;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_after;
      head_q <= head_q ^ pop;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q[0] <= res0_i;
      slot_q[1] <= res1_i;
    end
  end

endmodule

// File: rtl/fader_soft_takeover_and_button_toggle.sv
// Fader soft-takeover and button-toggle control surface, top level.
// Depends on fst_pkg, fst_ram, fst_cfg, fst_eval and fst_outbuf.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries surface button
// events, fader moves and host feedback. Output channel (out_valid_o /
// out_stall_i / out_data_o) carries LED, host-value and catch-status results,
// up to two per item, the last one flagged by last_result.
// Configuration is an APB-style port: bank-left at 0x0, bank-right at 0x4,
// catch tolerance at 0x8; write only while the block is idle.
// An item is registered at acceptance, its per-control values and
// flags come from the RAM reads started on that beat, and its results are
// loaded into the output buffer once they fit there, which then offers them
// from its slot registers, bounded by the single output beat per cycle.
// Throughput: one item per cycle while out_stall_i is low and each item yields
// at most one result; after an item with two, the next waits until both are sent.
// A stalled receiver holds the output buffer, then the input register, and
// then stalls the input channel.
// Reset loads the register defaults and starts a clearing pass over all
// NUM_CONTROLS entries (128 by default) of the flag RAM; the input is
// stalled during the pass. The value RAMs need no clearing.
module fader_soft_takeover_and_button_toggle
  import fst_pkg::*;
#(
  parameter int NUM_CONTROLS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fst_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fst_out_t              out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W  = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
  localparam int FLAG_W = $bits(fst_flags_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CONTROLS - 1);

  fst_cfg_t          cfg;
  fst_in_t           item_q;
  logic              item_valid_q;
  logic              accept;
  logic              fire;
  logic              load;
  logic              load_ok;
  logic              in_range;
  logic [IDX_W-1:0]  idx_in;
  logic [IDX_W-1:0]  idx_q;
  logic [7:0]        num_in_ext;
  logic [7:0]        num_q_ext;

  logic              clr_busy_q;
  logic [IDX_W-1:0]  clr_idx_q;
  fst_flags_t        flags_rd;
  fst_flags_t        flags_cur;
  fst_flags_t        flags_new;
  fst_flags_t        flags_wdata;
  logic              flags_we;
  logic              flag_we;
  logic [IDX_W-1:0]  flag_waddr;
  logic              fwd_flags_q;
  fst_flags_t        fwd_flags_val_q;

  fst_val_t   moved_rd;
  fst_val_t   pending_rd;
  logic       fwd_moved_q;
  fst_val_t   fwd_moved_val_q;
  logic       fwd_pending_q;
  fst_val_t   fwd_pending_val_q;
  fst_val_t   moved_cur;
  fst_val_t   pending_cur;

  fst_out_t   res0;
  fst_out_t   res1;
  logic [1:0] nres;
  fst_upd_t   upd;

  fst_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // control indexes
  assign num_in_ext = {1'b0, in_data_i.control_number};
  assign num_q_ext  = {1'b0, item_q.control_number};
  assign idx_in     = num_in_ext[IDX_W-1:0];
  assign idx_q      = num_q_ext[IDX_W-1:0];
  assign in_range   = (9'(item_q.control_number) < 9'(NUM_CONTROLS));

  // handshake: the held item leaves when its results fit in the buffer
  assign fire       = item_valid_q & ((nres == 2'd0) | load_ok);
  assign load       = fire & (nres != 2'd0);
  assign in_stall_o = clr_busy_q | (item_valid_q & ~fire);
  assign accept     = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= accept | (item_valid_q & ~fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // clearing pass over the flag RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == LAST_IDX) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
    end
  end

  // value stores
  fst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NUM_CONTROLS),
    .AW    (IDX_W)
  ) u_moved_ram (
    .clk_i   (clk_i),
    .we_i    (fire & upd.moved_we),
    .waddr_i (idx_q),
    .wdata_i (upd.moved_val),
    .re_i    (accept),
    .raddr_i (idx_in),
    .rdata_o (moved_rd)
  );

  fst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NUM_CONTROLS),
    .AW    (IDX_W)
  ) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (fire & upd.pending_we),
    .waddr_i (idx_q),
    .wdata_i (upd.pending_val),
    .re_i    (accept),
    .raddr_i (idx_in),
    .rdata_o (pending_rd)
  );

  // merge this item's flag updates into the current flags
  always_comb begin
    flags_new = flags_cur;
    if (upd.toggle_we) begin
      flags_new.toggle = upd.toggle_val;
    end
    if (upd.moved_we) begin
      flags_new.moved_valid = 1'b1;
    end
    if (upd.pending_valid_we) begin
      flags_new.pending_valid = upd.pending_valid_val;
    end
  end

  assign flags_we    = fire & (upd.toggle_we | upd.moved_we | upd.pending_valid_we);
  assign flag_we     = clr_busy_q | flags_we;
  assign flag_waddr  = clr_busy_q ? clr_idx_q : idx_q;
  assign flags_wdata = clr_busy_q ? fst_flags_t'('0) : flags_new;

  // flag store: toggle, moved valid and pending valid per control
  fst_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (NUM_CONTROLS),
    .AW    (IDX_W)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flags_wdata),
    .re_i    (accept),
    .raddr_i (idx_in),
    .rdata_o (flags_rd)
  );

  // forward a write that lands on the same control as the read beside it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_moved_q   <= 1'b0;
      fwd_pending_q <= 1'b0;
      fwd_flags_q   <= 1'b0;
    end else if (accept) begin
      fwd_moved_q   <= fire & upd.moved_we & (idx_q == idx_in);
      fwd_pending_q <= fire & upd.pending_we & (idx_q == idx_in);
      fwd_flags_q   <= flags_we & (idx_q == idx_in);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_moved_val_q   <= upd.moved_val;
      fwd_pending_val_q <= upd.pending_val;
      fwd_flags_val_q   <= flags_new;
    end
  end

  assign moved_cur   = fwd_moved_q ? fwd_moved_val_q : moved_rd;
  assign pending_cur = fwd_pending_q ? fwd_pending_val_q : pending_rd;
  assign flags_cur   = fwd_flags_q ? fwd_flags_val_q : flags_rd;

  fst_eval u_eval (
    .item_i          (item_q),
    .cfg_i           (cfg),
    .in_range_i      (in_range),
    .toggle_i        (flags_cur.toggle),
    .moved_valid_i   (flags_cur.moved_valid),
    .moved_i         (moved_cur),
    .pending_valid_i (flags_cur.pending_valid),
    .pending_i       (pending_cur),
    .res0_o          (res0),
    .res1_o          (res1),
    .nres_o          (nres),
    .upd_o           (upd)
  );

  fst_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res0_i      (res0),
    .res1_i      (res1),
    .nres_i      (nres),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
